@@ rtl/srbm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srbm_pkg
// Shared types and constants for the SPI register burst master.
// ----------------------------------------------------------------------------
package srbm_pkg;

  // Sequencer phase codes
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_SETUP = 2'd1;
  localparam logic [1:0] PH_HIGH  = 2'd2;
  localparam logic [1:0] PH_LOW   = 2'd3;

  // Address byte direction flag and address mask
  localparam logic [7:0] WRITE_FLAG = 8'h80;
  localparam logic [7:0] ADDR_MASK  = 8'h7F;

  // Reset value of the half period register
  localparam logic [7:0] HALF_PERIOD_RST = 8'd5;

  // Sequencer state except the byte counter, whose width is a parameter
  typedef struct packed {
    logic [1:0] phase;
    logic [7:0] shift_reg;
    logic [2:0] bit_index;
    logic [7:0] tick_count;
    logic       is_write_frame;
    logic       in_address_byte;
    logic       mosi_level;
  } seq_state_t;

  // One request as seen by the step logic
  typedef struct packed {
    logic       start_req;
    logic       mode;
    logic [6:0] reg_addr;
    logic [7:0] byte_count;
    logic [7:0] write_byte;
    logic       miso;
  } req_t;

  // One result
  typedef struct packed {
    logic       cs_n;
    logic       sclk;
    logic       mosi;
    logic       busy_res;
    logic       byte_taken;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       last;
    logic       frame_done;
  } res_t;

endpackage

@@ rtl/spi_register_burst_master.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_register_burst_master
// Mode-0 SPI master for register bursts, stepped one tick per request.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid_i / in_ready_o, tick fields      | sink
//  out     | out_valid_o / out_ready_i, pin fields     | source
//  cfg     | cfg_we_i, cfg_wdata_i (half period ticks) | sink
//
//  Each request sits in the input register while the step logic works on
//  it, then its result is registered in the result register; with the output
//  side ready, one request is taken every cycle. A stalled output register
//  holds the input register, which then drops in_ready_o. Reset empties both
//  registers, idles the sequencer and sets the half period to 5.
// ----------------------------------------------------------------------------
module spi_register_burst_master import srbm_pkg::*; #(
  parameter int COUNT_BITS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       start_req_i,
  input  logic       mode_i,
  input  logic [6:0] reg_addr_i,
  input  logic [7:0] byte_count_i,
  input  logic [7:0] write_byte_i,
  input  logic       miso_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       cs_n_o,
  output logic       sclk_o,
  output logic       mosi_o,
  output logic       busy_res_o,
  output logic       byte_taken_o,
  output logic [7:0] read_byte_o,
  output logic       read_valid_o,
  output logic       last_o,
  output logic       frame_done_o
);

  logic [7:0]            half_period_q;
  logic                  in_valid_q;
  req_t                  req_q;
  seq_state_t            state_q, state_d;
  logic [COUNT_BITS-1:0] bytes_left_q, bytes_left_d;
  logic                  out_valid_q;
  res_t                  res_q, res_d;
  logic                  advance;

  // Pipeline control
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= HALF_PERIOD_RST;
    end else if (cfg_we_i) begin
      half_period_q <= cfg_wdata_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q.start_req  <= start_req_i;
      req_q.mode       <= mode_i;
      req_q.reg_addr   <= reg_addr_i;
      req_q.byte_count <= byte_count_i;
      req_q.write_byte <= write_byte_i;
      req_q.miso       <= miso_i;
    end
  end

  // Step logic
  srbm_step #(
    .COUNT_BITS (COUNT_BITS)
  ) u_step (
    .state_i       (state_q),
    .bytes_left_i  (bytes_left_q),
    .half_period_i (half_period_q),
    .req_i         (req_q),
    .state_o       (state_d),
    .bytes_left_o  (bytes_left_d),
    .res_o         (res_d)
  );

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= '0;
      bytes_left_q <= '0;
    end else if (advance) begin
      state_q      <= state_d;
      bytes_left_q <= bytes_left_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cs_n_o       = res_q.cs_n;
  assign sclk_o       = res_q.sclk;
  assign mosi_o       = res_q.mosi;
  assign busy_res_o   = res_q.busy_res;
  assign byte_taken_o = res_q.byte_taken;
  assign read_byte_o  = res_q.read_byte;
  assign read_valid_o = res_q.read_valid;
  assign last_o       = res_q.last;
  assign frame_done_o = res_q.frame_done;

  // Checks
  a_no_take_and_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(res_q.byte_taken && res_q.read_valid))
    else $error("byte taken and read byte completed on the same tick");

  a_last_needs_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.last) |-> (res_q.byte_taken || res_q.read_valid))
    else $error("last flagged without a data byte");

  a_done_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.frame_done) |-> (res_q.cs_n && !res_q.sclk))
    else $error("frame done while chip select still low");

  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("sequencer state moved without a request");

endmodule

@@ rtl/srbm_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srbm_step
// One tick of the SPI sequencer: next state and the pin result, combinational.
// ----------------------------------------------------------------------------
module srbm_step import srbm_pkg::*; #(
  parameter int COUNT_BITS = 8
) (
  input  seq_state_t            state_i,
  input  logic [COUNT_BITS-1:0] bytes_left_i,
  input  logic [7:0]            half_period_i,
  input  req_t                  req_i,
  output seq_state_t            state_o,
  output logic [COUNT_BITS-1:0] bytes_left_o,
  output res_t                  res_o
);

  logic [2:0]            mosi_idx;
  logic [2:0]            bit_inc;
  logic [7:0]            shifted;
  logic                  level_end;
  logic [7:0]            tick_inc;
  logic [7:0]            addr_byte;
  logic                  taken;
  logic                  rvalid;
  logic [7:0]            rbyte;
  logic                  lastf;
  logic                  done;
  seq_state_t            nxt;
  logic [COUNT_BITS-1:0] bl_nxt;

  assign mosi_idx  = 3'd6 - state_i.bit_index;
  assign bit_inc   = state_i.bit_index + 3'd1;
  assign shifted   = {state_i.shift_reg[6:0], req_i.miso};
  assign level_end = !(state_i.tick_count < half_period_i);
  assign tick_inc  = state_i.tick_count + 8'd1;
  assign addr_byte = req_i.mode ? ({1'b0, req_i.reg_addr} | WRITE_FLAG)
                                : ({1'b0, req_i.reg_addr} & ADDR_MASK);

  // Sequencer transition
  always_comb begin
    nxt    = state_i;
    bl_nxt = bytes_left_i;
    taken  = 1'b0;
    rvalid = 1'b0;
    rbyte  = 8'd0;
    lastf  = 1'b0;
    done   = 1'b0;
    unique case (state_i.phase)
      PH_IDLE: begin
        if (req_i.start_req) begin
          nxt.is_write_frame  = req_i.mode;
          nxt.shift_reg       = addr_byte;
          nxt.mosi_level      = addr_byte[7];
          nxt.bit_index       = 3'd0;
          nxt.in_address_byte = 1'b1;
          bl_nxt              = COUNT_BITS'(req_i.byte_count);
          nxt.tick_count      = 8'd0;
          nxt.phase           = PH_SETUP;
        end
      end
      PH_SETUP: begin
        nxt.phase      = PH_HIGH;
        nxt.tick_count = 8'd1;
      end
      PH_HIGH: begin
        if (!level_end) begin
          nxt.tick_count = tick_inc;
        end else begin
          // falling edge: next MOSI bit, or take the next write byte
          nxt.phase      = PH_LOW;
          nxt.tick_count = 8'd1;
          if (state_i.bit_index != 3'd7) begin
            if (state_i.in_address_byte || state_i.is_write_frame) begin
              nxt.mosi_level = state_i.shift_reg[mosi_idx];
            end
          end else if ((bytes_left_i != '0) && state_i.is_write_frame) begin
            nxt.shift_reg  = req_i.write_byte;
            nxt.mosi_level = req_i.write_byte[7];
            taken          = 1'b1;
            lastf          = (bytes_left_i == COUNT_BITS'(1));
          end
        end
      end
      PH_LOW: begin
        priority if (!level_end) begin
          nxt.tick_count = tick_inc;
        end else if (state_i.bit_index != 3'd7) begin
          // rising edge inside a byte; sample MISO on read data bytes
          nxt.bit_index = bit_inc;
          if (!state_i.in_address_byte && !state_i.is_write_frame) begin
            nxt.shift_reg = shifted;
            if (bit_inc == 3'd7) begin
              rvalid = 1'b1;
              rbyte  = shifted;
              lastf  = (bytes_left_i == '0);
            end
          end
          nxt.phase      = PH_HIGH;
          nxt.tick_count = 8'd1;
        end else if (bytes_left_i == '0) begin
          // end of frame
          nxt.phase           = PH_IDLE;
          nxt.tick_count      = 8'd0;
          nxt.bit_index       = 3'd0;
          nxt.in_address_byte = 1'b0;
          done                = 1'b1;
        end else begin
          // next data byte
          bl_nxt              = bytes_left_i - COUNT_BITS'(1);
          nxt.bit_index       = 3'd0;
          nxt.in_address_byte = 1'b0;
          if (!state_i.is_write_frame) begin
            nxt.shift_reg = {7'd0, req_i.miso};
          end
          nxt.phase      = PH_HIGH;
          nxt.tick_count = 8'd1;
        end
      end
      default: begin
        nxt = state_i;
      end
    endcase
  end

  // Pin result from the state after the tick
  always_comb begin
    res_o.cs_n       = (nxt.phase == PH_IDLE);
    res_o.sclk       = (nxt.phase == PH_HIGH);
    res_o.mosi       = nxt.mosi_level;
    res_o.busy_res   = (nxt.phase != PH_IDLE);
    res_o.byte_taken = taken;
    res_o.read_byte  = rbyte;
    res_o.read_valid = rvalid;
    res_o.last       = lastf;
    res_o.frame_done = done;
  end

  assign state_o      = nxt;
  assign bytes_left_o = bl_nxt;

endmodule

@@ tb/tb_spi_register_burst_master.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_spi_register_burst_master
// Self-checking bench for the SPI register burst master. Tick requests are
// queued as whole frames (start, then random MISO / write data, with stray
// starts that must be ignored) and fed through a valid/ready driver. A
// cycle-level model of the serial sequencer predicts the pin state for every
// accepted tick, and a monitor compares each returned result field by field.
// ----------------------------------------------------------------------------
module tb_spi_register_burst_master import srbm_pkg::*;;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 150;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [7:0] cfg_wdata_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic       start_req_i = 1'b0;
  logic       mode_i = 1'b0;
  logic [6:0] reg_addr_i = '0;
  logic [7:0] byte_count_i = '0;
  logic [7:0] write_byte_i = '0;
  logic       miso_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic       cs_n_o;
  logic       sclk_o;
  logic       mosi_o;
  logic       busy_res_o;
  logic       byte_taken_o;
  logic [7:0] read_byte_o;
  logic       read_valid_o;
  logic       last_o;
  logic       frame_done_o;

  spi_register_burst_master dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .start_req_i  (start_req_i),
    .mode_i       (mode_i),
    .reg_addr_i   (reg_addr_i),
    .byte_count_i (byte_count_i),
    .write_byte_i (write_byte_i),
    .miso_i       (miso_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .cs_n_o       (cs_n_o),
    .sclk_o       (sclk_o),
    .mosi_o       (mosi_o),
    .busy_res_o   (busy_res_o),
    .byte_taken_o (byte_taken_o),
    .read_byte_o  (read_byte_o),
    .read_valid_o (read_valid_o),
    .last_o       (last_o),
    .frame_done_o (frame_done_o)
  );

  // Pending tick requests and expected pin states
  req_t tick_q[$];
  res_t pins_q[$];

  // Sequencer model state and its copy of the half period register
  seq_state_t seq;
  logic [7:0] seq_left;
  logic [7:0] half_period;

  int   mismatches = 0;
  int   cycles = 0;
  int   queued = 0;
  bit   req_fire = 1'b0;
  bit   gaps_on = 1'b1;
  int   hold_asked = 0;
  int   hold_served = 0;
  int   hold_left = 0;
  req_t next_req;
  req_t seen_req;
  res_t want;

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Advance the sequencer model by one tick, return the pins after it
  function automatic res_t spi_tick(input req_t rq);
    res_t r;
    r = '0;
    case (seq.phase)
      PH_IDLE: begin
        if (rq.start_req) begin
          seq.is_write_frame  = rq.mode;
          seq.shift_reg       = rq.mode ? ({1'b0, rq.reg_addr} | WRITE_FLAG)
                                        : ({1'b0, rq.reg_addr} & ADDR_MASK);
          seq.mosi_level      = seq.shift_reg[7];
          seq.bit_index       = '0;
          seq.in_address_byte = 1'b1;
          seq_left            = rq.byte_count;
          seq.tick_count      = '0;
          seq.phase           = PH_SETUP;
        end
      end
      PH_SETUP: begin
        seq.phase      = PH_HIGH;
        seq.tick_count = 8'd1;
      end
      PH_HIGH: begin
        if (seq.tick_count < half_period) begin
          seq.tick_count = seq.tick_count + 8'd1;
        end else begin
          seq.phase      = PH_LOW;
          seq.tick_count = 8'd1;
          if (seq.bit_index < 3'd7) begin
            if (seq.in_address_byte || seq.is_write_frame)
              seq.mosi_level = seq.shift_reg[3'd6 - seq.bit_index];
          end else if (seq_left != 0 && seq.is_write_frame) begin
            // next write byte latched on the falling edge of bit 7
            seq.shift_reg  = rq.write_byte;
            seq.mosi_level = rq.write_byte[7];
            r.byte_taken   = 1'b1;
            r.last         = (seq_left == 8'd1);
          end
        end
      end
      default: begin
        if (seq.tick_count < half_period) begin
          seq.tick_count = seq.tick_count + 8'd1;
        end else if (seq.bit_index < 3'd7) begin
          seq.bit_index = seq.bit_index + 3'd1;
          if (!seq.in_address_byte && !seq.is_write_frame) begin
            seq.shift_reg = {seq.shift_reg[6:0], rq.miso};
            if (seq.bit_index == 3'd7) begin
              r.read_valid = 1'b1;
              r.read_byte  = seq.shift_reg;
              r.last       = (seq_left == 0);
            end
          end
          seq.phase      = PH_HIGH;
          seq.tick_count = 8'd1;
        end else if (seq_left == 0) begin
          // end of frame: chip select rises
          seq.phase           = PH_IDLE;
          seq.tick_count      = '0;
          seq.bit_index       = '0;
          seq.in_address_byte = 1'b0;
          r.frame_done        = 1'b1;
        end else begin
          seq_left            = seq_left - 8'd1;
          seq.bit_index       = '0;
          seq.in_address_byte = 1'b0;
          if (!seq.is_write_frame) seq.shift_reg = {7'd0, rq.miso};
          seq.phase      = PH_HIGH;
          seq.tick_count = 8'd1;
        end
      end
    endcase
    r.cs_n     = (seq.phase == PH_IDLE);
    r.sclk     = (seq.phase == PH_HIGH);
    r.mosi     = seq.mosi_level;
    r.busy_res = (seq.phase != PH_IDLE);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    $display("mismatch %s: got %0h, expected %0h (cycle %0d)", what, got, exp_val, cycles);
    mismatches++;
  endtask

  task automatic check_field(input string what, input int got, input int exp_val);
    if (got != exp_val) report_mismatch(what, got, exp_val);
  endtask

  // Acceptance, prediction and result check at the rising edge
  always @(posedge clk_i) begin
    req_fire = in_valid_i && in_ready_o;
    if (req_fire) begin
      seen_req.start_req  = start_req_i;
      seen_req.mode       = mode_i;
      seen_req.reg_addr   = reg_addr_i;
      seen_req.byte_count = byte_count_i;
      seen_req.write_byte = write_byte_i;
      seen_req.miso       = miso_i;
      pins_q.push_back(spi_tick(seen_req));
    end
    if (out_valid_o && out_ready_i) begin
      if (pins_q.size() == 0) begin
        report_mismatch("result with nothing pending", 1, 0);
      end else begin
        want = pins_q.pop_front();
        check_field("cs_n", cs_n_o, want.cs_n);
        check_field("sclk", sclk_o, want.sclk);
        check_field("mosi", mosi_o, want.mosi);
        check_field("busy", busy_res_o, want.busy_res);
        check_field("byte_taken", byte_taken_o, want.byte_taken);
        check_field("read_byte", read_byte_o, want.read_byte);
        check_field("read_valid", read_valid_o, want.read_valid);
        check_field("last", last_o, want.last);
        check_field("frame_done", frame_done_o, want.frame_done);
      end
    end
  end

  // Request driver: loads the next tick once the current one is taken
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || req_fire)) begin
      if (tick_q.size() > 0 && !(gaps_on && $urandom_range(99) < 29)) begin
        next_req = tick_q.pop_front();
        start_req_i  <= next_req.start_req;
        mode_i       <= next_req.mode;
        reg_addr_i   <= next_req.reg_addr;
        byte_count_i <= next_req.byte_count;
        write_byte_i <= next_req.write_byte;
        miso_i       <= next_req.miso;
        in_valid_i   <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls plus requested long hold-offs
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (hold_asked != hold_served) begin
      hold_served++;
      hold_left = HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= !(gaps_on && $urandom_range(99) < 29);
    end
  end

  task automatic queue_tick(input bit start, input bit md, input int addr, input int cnt,
                            input int wbyte, input bit sdi);
    req_t rq;
    rq.start_req  = start;
    rq.mode       = md;
    rq.reg_addr   = addr[6:0];
    rq.byte_count = cnt[7:0];
    rq.write_byte = wbyte[7:0];
    rq.miso       = sdi;
    tick_q.push_back(rq);
    queued++;
  endtask

  // Ticks with no start; other fields random
  task automatic queue_idle(input int n);
    repeat (n) queue_tick(1'b0, 1'($urandom_range(1)), $urandom_range(127),
                          $urandom_range(255), $urandom_range(255),
                          1'($urandom_range(1)));
  endtask

  // One whole frame; wfill above 255 means random write data.
  // Stray starts inside the frame must be ignored by a busy sequencer.
  task automatic queue_frame(input bit md, input int addr, input int cnt, input int wfill,
                             output int n_ticks);
    int h;
    int body;
    h = (half_period == 0) ? 1 : half_period;
    body = 1 + (cnt + 1) * 16 * h;
    queue_tick(1'b1, md, addr, cnt, $urandom_range(255), 1'($urandom_range(1)));
    repeat (body)
      queue_tick($urandom_range(9) == 0, 1'($urandom_range(1)), $urandom_range(127),
                 $urandom_range(255), (wfill > 255) ? $urandom_range(255) : wfill,
                 1'($urandom_range(1)));
    n_ticks = body + 1;
  endtask

  // Wait until every queued tick is sent and every result has come back
  task automatic wait_drained();
    while (tick_q.size() != 0 || in_valid_i || pins_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_period(input int value);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value[7:0];
    half_period  = value[7:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Stimulus
  initial begin
    int n;
    int frames;
    seq         = '0;
    seq_left    = '0;
    half_period = HALF_PERIOD_RST;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset period, then address and data extremes at period 1
    queue_frame(1'b0, 127, 0, 256, n);
    queue_idle(2);
    write_period(1);
    queue_frame(1'b1, 0, 2, 255, n);
    queue_frame(1'b1, 85, 1, 0, n);
    queue_frame(1'b0, 42, 1, 256, n);
    queue_idle(3);

    // zero half period acts as one tick; multi-byte burst
    write_period(0);
    queue_frame(1'b0, 1, 3, 256, n);
    queue_idle(2);

    // longest period, then shortened while a level is in progress
    write_period(255);
    queue_tick(1'b1, 1'b1, 93, 0, 0, 1'b0);
    queue_idle(20);
    write_period(1);
    queue_idle(30);

    // random frames
    frames = 0;
    while (queued < 950) begin
      if (frames % 6 == 5) write_period($urandom_range(3));
      if (frames == 3) gaps_on = 1'b0;
      if (frames == 7) gaps_on = 1'b1;
      if ($urandom_range(4) == 0)
        queue_frame(1'($urandom_range(1)), $urandom_range(127), $urandom_range(4, 9),
                    256, n);
      else
        queue_frame(1'($urandom_range(1)), $urandom_range(127), $urandom_range(3), 256, n);
      // long receiver hold-off while the sender keeps offering ticks
      if (frames == 1) hold_asked++;
      n = $urandom_range(3);
      queue_idle(n);
      frames++;
      // occasionally let everything drain before going on
      if ($urandom_range(7) == 0) wait_drained();
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
